>>> sv/iotlb_pkg.sv
`default_nettype none

package iotlb_pkg;

  localparam int unsigned ENTRIES     = 2;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);
  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned PG_OFF_W    = $clog2(PAGE_BYTES);
  localparam int unsigned VA_W        = 64;
  localparam int unsigned VPN_W       = 52;
  localparam int unsigned PPN_W       = 44;
  localparam int unsigned PA_W        = 56;
  localparam int unsigned SIZE_W      = 57;
  localparam int unsigned CTX_W       = 38;
  localparam int unsigned ATTR_W      = 13;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_FILL   = 1'b1;

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FLT  = 2'd2;
  localparam logic [1:0] ST_FILL = 2'd3;

  localparam int unsigned AT_VS_R   = 0;
  localparam int unsigned AT_VS_W   = 1;
  localparam int unsigned AT_VS_X   = 2;
  localparam int unsigned AT_VS_D   = 3;
  localparam int unsigned AT_U      = 4;
  localparam int unsigned AT_G      = 5;
  localparam int unsigned AT_PBMT_L = 6;
  localparam int unsigned AT_G_R    = 8;
  localparam int unsigned AT_G_W    = 9;
  localparam int unsigned AT_G_X    = 10;
  localparam int unsigned AT_G_D    = 11;
  localparam int unsigned AT_NAPOT  = 12;

  localparam int unsigned ACC_R = 0;
  localparam int unsigned ACC_W = 1;
  localparam int unsigned ACC_X = 2;

  typedef struct packed {
    logic              command;
    logic [VA_W-1:0]   virt_addr;
    logic [VPN_W-1:0]  virt_page;
    logic              gscid_valid;
    logic              pscid_valid;
    logic [15:0]       guest_ctx_id;
    logic [19:0]       proc_ctx_id;
    logic              priv_mode;
    logic [2:0]        access_flags;
    logic              sum_enable;
    logic [ATTR_W-1:0] entry_attrs;
    logic [PPN_W-1:0]  phys_page;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PA_W-1:0]   phys_addr;
    logic [SIZE_W-1:0] page_size;
    logic              perm_read;
    logic              perm_write;
    logic              perm_exec;
    logic              global_page;
    logic [1:0]        mem_type;
  } rsp_t;

  typedef struct packed {
    logic req_load;
    logic match_load;
    logic resp_exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rsp_full;
  } ctrl_sts_t;

endpackage

`default_nettype wire

>>> sv/iotlb_req_if.sv
`default_nettype none

interface iotlb_req_if import iotlb_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/iotlb_rsp_if.sv
`default_nettype none

interface iotlb_rsp_if import iotlb_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/iotlb_ctrl.sv
`default_nettype none

module iotlb_ctrl import iotlb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_RESP  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd_o.match_load = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!sts_i.rsp_full) begin
          cmd_o.resp_exec = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/iotlb_dpath.sv
`default_nettype none

module iotlb_dpath import iotlb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire req_t      req_data_i,
  input  wire ctrl_cmd_t cmd_i,
  output ctrl_sts_t      sts_o,
  output logic           rsp_valid_o,
  input  wire logic      rsp_ready_i,
  output rsp_t           rsp_data_o
);

  req_t              req_q;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [ENTRIES-1:0] lru_q, lru_d;
  logic [VPN_W-1:0]  tag_page_q  [ENTRIES];
  logic [CTX_W-1:0]  tag_ctx_q   [ENTRIES];
  logic [ATTR_W-1:0] attr_q      [ENTRIES];
  logic [PPN_W-1:0]  ppn_q       [ENTRIES];
  logic              found_q;
  logic [IDX_W-1:0]  hit_q;
  logic              rsp_valid_q;
  rsp_t              rsp_q, rsp_d;

  logic [CTX_W-1:0]   req_ctx;
  logic [VPN_W-1:0]   vpn;
  logic [ENTRIES-1:0] match;
  logic [IDX_W-1:0]   fill_slot;
  logic               wr_fill;

  assign req_ctx = {req_q.gscid_valid, req_q.pscid_valid, req_q.guest_ctx_id,
                    req_q.proc_ctx_id};
  assign vpn = req_q.virt_addr[VA_W-1:PG_OFF_W];

  // napot-masked tag compare per entry
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cmp
    logic [VPN_W-1:0] tag_inc;
    logic [VPN_W-1:0] tag_mask;
    assign tag_inc  = tag_page_q[k] + VPN_W'(1);
    assign tag_mask = attr_q[k][AT_NAPOT] ? (tag_inc ^ tag_page_q[k])
                                          : '0;
    assign match[k] = valid_q[k] && (tag_ctx_q[k] == req_ctx)
                      && (((vpn ^ tag_page_q[k]) & ~tag_mask) == '0);
  end

  always_comb begin
    if (!valid_q[0]) begin
      fill_slot = IDX_W'(0);
    end else if (!valid_q[1]) begin
      fill_slot = IDX_W'(1);
    end else if (lru_q[1]) begin
      fill_slot = IDX_W'(1);
    end else begin
      fill_slot = IDX_W'(0);
    end
  end

  // selected entry for the response step
  logic [ATTR_W-1:0] a;
  logic [PPN_W-1:0]  ppn;
  logic [PPN_W-1:0]  ppn_inc;
  logic [PPN_W-1:0]  ppn_mask;
  logic [PA_W-1:0]   size_mask;
  logic              rd, wr, ex, pr, sum, u;
  logic              s1_fault, g_fail;

  assign a        = attr_q[hit_q];
  assign ppn      = ppn_q[hit_q];
  assign ppn_inc  = ppn + PPN_W'(1);
  assign ppn_mask = a[AT_NAPOT] ? (ppn_inc ^ ppn) : '0;
  assign size_mask = {ppn_mask, {PG_OFF_W{1'b1}}};

  assign rd  = req_q.access_flags[ACC_R];
  assign wr  = req_q.access_flags[ACC_W];
  assign ex  = req_q.access_flags[ACC_X];
  assign pr  = req_q.priv_mode;
  assign sum = req_q.sum_enable;
  assign u   = a[AT_U];

  assign s1_fault = (ex && !a[AT_VS_X]) || (rd && !a[AT_VS_R]) || (wr && !a[AT_VS_W])
                    || (!pr && !u) || (ex && pr && u) || (pr && !ex && !sum && u);
  assign g_fail   = (ex && !a[AT_G_X]) || (rd && !a[AT_G_R]) || (wr && !a[AT_G_W])
                    || (wr && (!a[AT_VS_D] || !a[AT_G_D]));

  always_comb begin
    valid_d = valid_q;
    lru_d   = lru_q;
    rsp_d   = '0;
    wr_fill = 1'b0;
    if (req_q.command == CMD_FILL) begin
      wr_fill = 1'b1;
      valid_d[fill_slot] = 1'b1;
      rsp_d.status = ST_FILL;
    end else if (!found_q) begin
      rsp_d.status = ST_MISS;
    end else begin
      for (int k = 0; k < ENTRIES; k++) begin
        lru_d[k] = (IDX_W'(k) != hit_q);
      end
      if (s1_fault) begin
        rsp_d.status = ST_FLT;
      end else if (g_fail) begin
        valid_d[hit_q] = 1'b0;
        rsp_d.status = ST_MISS;
      end else begin
        rsp_d.status      = ST_HIT;
        rsp_d.phys_addr   = ({ppn, {PG_OFF_W{1'b0}}} & ~size_mask)
                            | (req_q.virt_addr[PA_W-1:0] & size_mask);
        rsp_d.page_size   = {1'b0, size_mask} + {{(SIZE_W-1){1'b0}}, 1'b1};
        rsp_d.perm_read   = a[AT_VS_R] & a[AT_G_R];
        rsp_d.perm_write  = a[AT_VS_W] & a[AT_G_W];
        rsp_d.perm_exec   = a[AT_VS_X] & a[AT_G_X];
        rsp_d.global_page = a[AT_G];
        rsp_d.mem_type    = a[AT_PBMT_L+1:AT_PBMT_L];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_q <= req_data_i;
    end
    if (cmd_i.match_load) begin
      found_q <= |match;
      hit_q   <= match[0] ? IDX_W'(0) : IDX_W'(1);
    end
    if (cmd_i.resp_exec) begin
      rsp_q <= rsp_d;
      if (wr_fill) begin
        tag_page_q[fill_slot] <= req_q.virt_page;
        tag_ctx_q[fill_slot]  <= req_ctx;
        attr_q[fill_slot]     <= req_q.entry_attrs;
        ppn_q[fill_slot]      <= req_q.phys_page;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      lru_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.resp_exec) begin
        valid_q     <= valid_d;
        lru_q       <= lru_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.rsp_full = rsp_valid_q && !rsp_ready_i;
  assign rsp_valid_o    = rsp_valid_q;
  assign rsp_data_o     = rsp_q;

endmodule

`default_nettype wire

>>> sv/iotlb_two_stage_lookup_core.sv
// channel | dir | handshake          | payload
// req_i   | in  | valid/ready, sink  | command, address, context tags, fill entry
// rsp_o   | out | valid/ready, source| status, phys addr, page size, perms
//
// every request passes through accept, tag compare, then response and state update
// the response step waits while the output register holds an untaken response
// a new request is accepted while an earlier response still waits on rsp_o
// reset clears the controller state, the valid and lru bits and the output valid
`default_nettype none

module iotlb_two_stage_lookup_core import iotlb_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  iotlb_req_if.sink  req_i,
  iotlb_rsp_if.source rsp_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  iotlb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  iotlb_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_data_i  (req_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_data_o  (rsp_o.data)
  );

endmodule

`default_nettype wire

>>> sv/iotlb_checker.sv
`default_nettype none

module iotlb_checker import iotlb_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid_i,
  input wire logic req_ready_i,
  input wire logic rsp_valid_i,
  input wire logic rsp_ready_i,
  input wire rsp_t rsp_data_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

  a_nonhit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.status != ST_HIT)
      |-> (rsp_data_i.page_size == '0) && (rsp_data_i.phys_addr == '0))
    else $error("non-hit response carries data");

  a_hit_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.status == ST_HIT)
      |-> $onehot(rsp_data_i.page_size) && (rsp_data_i.page_size[PG_OFF_W-1:0] == '0))
    else $error("hit page size malformed");

endmodule

bind iotlb_two_stage_lookup_core iotlb_checker u_iotlb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

`default_nettype wire

>>> test/iotlb_lookup_checker.sv
`default_nettype none

module iotlb_lookup_checker import iotlb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iotlb_req_if      req_mon,
  iotlb_rsp_if      rsp_mon,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic              ent_valid [ENTRIES];
  logic              ent_lru   [ENTRIES];
  logic [VPN_W-1:0]  ent_page  [ENTRIES];
  logic [CTX_W-1:0]  ent_ctx   [ENTRIES];
  logic [ATTR_W-1:0] ent_attr  [ENTRIES];
  logic [PPN_W-1:0]  ent_ppn   [ENTRIES];
  rsp_t              expected_rsp [$];

  function automatic rsp_t translate(input req_t r);
    rsp_t              rsp;
    logic [CTX_W-1:0]  ctx;
    logic [VPN_W-1:0]  vpn;
    logic [VPN_W-1:0]  mask;
    logic [ATTR_W-1:0] a;
    logic [63:0]       ppn;
    logic [63:0]       pages;
    logic [63:0]       size;
    logic [63:0]       pa;
    logic              rd;
    logic              wr;
    logic              ex;
    logic              sup;
    logic              usr;
    int                slot;
    int                hit;
    rsp = '0;
    ctx = {r.gscid_valid, r.pscid_valid, r.guest_ctx_id, r.proc_ctx_id};
    if (r.command == CMD_FILL) begin
      if (!ent_valid[0]) slot = 0;
      else if (!ent_valid[1]) slot = 1;
      else if (ent_lru[1]) slot = 1;
      else slot = 0;
      ent_page[slot]  = r.virt_page;
      ent_ctx[slot]   = ctx;
      ent_attr[slot]  = r.entry_attrs;
      ent_ppn[slot]   = r.phys_page;
      ent_valid[slot] = 1'b1;
      rsp.status = ST_FILL;
      return rsp;
    end
    vpn = r.virt_addr[VA_W-1:PG_OFF_W];
    hit = -1;
    for (int k = 0; k < ENTRIES; k++) begin
      if (hit < 0 && ent_valid[k] && ent_ctx[k] == ctx) begin
        mask = ent_attr[k][AT_NAPOT] ? (ent_page[k] ^ (ent_page[k] + 1'b1)) : '0;
        if (((vpn ^ ent_page[k]) & ~mask) == '0) hit = k;
      end
    end
    if (hit < 0) begin
      rsp.status = ST_MISS;
      return rsp;
    end
    for (int k = 0; k < ENTRIES; k++) ent_lru[k] = (k != hit);
    a   = ent_attr[hit];
    rd  = r.access_flags[ACC_R];
    wr  = r.access_flags[ACC_W];
    ex  = r.access_flags[ACC_X];
    sup = r.priv_mode;
    usr = a[AT_U];
    if ((ex && !a[AT_VS_X]) || (rd && !a[AT_VS_R]) || (wr && !a[AT_VS_W]) ||
        (!sup && !usr) || (ex && sup && usr) ||
        (sup && !ex && !r.sum_enable && usr)) begin
      rsp.status = ST_FLT;
      return rsp;
    end
    if ((ex && !a[AT_G_X]) || (rd && !a[AT_G_R]) || (wr && !a[AT_G_W]) ||
        (wr && (!a[AT_VS_D] || !a[AT_G_D]))) begin
      ent_valid[hit] = 1'b0;
      rsp.status = ST_MISS;
      return rsp;
    end
    ppn   = 64'(ent_ppn[hit]);
    pages = a[AT_NAPOT] ? ((ppn ^ (ppn + 64'd1)) + 64'd1) : 64'd1;
    if (pages > (64'd1 << PPN_W)) pages = 64'd1 << PPN_W;
    size = pages << PG_OFF_W;
    pa   = ((ppn << PG_OFF_W) & ~(size - 64'd1)) | (r.virt_addr & (size - 64'd1));
    rsp.status      = ST_HIT;
    rsp.phys_addr   = pa[PA_W-1:0];
    rsp.page_size   = size[SIZE_W-1:0];
    rsp.perm_read   = a[AT_VS_R] & a[AT_G_R];
    rsp.perm_write  = a[AT_VS_W] & a[AT_G_W];
    rsp.perm_exec   = a[AT_VS_X] & a[AT_G_X];
    rsp.global_page = a[AT_G];
    rsp.mem_type    = a[AT_PBMT_L +: 2];
    return rsp;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count_o++;
    end
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    for (int k = 0; k < ENTRIES; k++) begin
      ent_valid[k] = 1'b0;
      ent_lru[k]   = 1'b0;
    end
  end

  always @(posedge clk_i) begin : monitor
    rsp_t got;
    rsp_t want;
    if (!rst_ni) begin
      for (int k = 0; k < ENTRIES; k++) begin
        ent_valid[k] = 1'b0;
        ent_lru[k]   = 1'b0;
      end
      expected_rsp.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.data;
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual 0x%0h", $time, got);
          fail_count_o++;
        end else begin
          want = expected_rsp.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("phys_addr", 64'(want.phys_addr), 64'(got.phys_addr));
          check_field("page_size", 64'(want.page_size), 64'(got.page_size));
          check_field("perm_read", 64'(want.perm_read), 64'(got.perm_read));
          check_field("perm_write", 64'(want.perm_write), 64'(got.perm_write));
          check_field("perm_exec", 64'(want.perm_exec), 64'(got.perm_exec));
          check_field("global_page", 64'(want.global_page), 64'(got.global_page));
          check_field("mem_type", 64'(want.mem_type), 64'(got.mem_type));
        end
      end
      if (req_mon.valid && req_mon.ready) expected_rsp.push_back(translate(req_mon.data));
    end
    pending_o = expected_rsp.size();
  end
endmodule

`default_nettype wire

>>> test/iotlb_two_stage_lookup_core_tb.sv
`default_nettype none

module iotlb_two_stage_lookup_core_tb import iotlb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM   = 1500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RECENT_MAX   = 6;

  localparam logic [ATTR_W-1:0] PERM_ALL =
    ATTR_W'((1 << AT_VS_R) | (1 << AT_VS_W) | (1 << AT_VS_X) | (1 << AT_VS_D) |
            (1 << AT_G_R) | (1 << AT_G_W) | (1 << AT_G_X) | (1 << AT_G_D));
  localparam logic [ATTR_W-1:0] ATTR_SUPER   = PERM_ALL | ATTR_W'((1 << AT_G) |
                                                                  (2 << AT_PBMT_L));
  localparam logic [ATTR_W-1:0] ATTR_CLEAN   = PERM_ALL & ~ATTR_W'(1 << AT_VS_D);
  localparam logic [ATTR_W-1:0] ATTR_G_RONLY =
    ATTR_W'((1 << AT_VS_R) | (1 << AT_VS_W) | (1 << AT_VS_X) | (1 << AT_VS_D) |
            (1 << AT_G_R) | (1 << AT_G_D) | (1 << AT_NAPOT) | (1 << AT_PBMT_L));
  localparam logic [ATTR_W-1:0] ATTR_NO_VS   =
    ATTR_W'((1 << AT_G_R) | (1 << AT_G_W) | (1 << AT_G_X) | (1 << AT_G_D));
  localparam logic [CTX_W-1:0]  CTX_MID      = {1'b0, 1'b1, 16'h5A5A, 20'h12345};

  typedef struct {
    logic [CTX_W-1:0] ctx;
    logic [VPN_W-1:0] page;
    logic             napot;
  } fill_tag_t;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             steady = 1'b0;
  int               cycle_count = 0;
  int               fail_count;
  int               pending;
  fill_tag_t        recent_fill [$];
  logic [CTX_W-1:0] ctx_pool [4];

  iotlb_req_if req_ch ();
  iotlb_rsp_if rsp_ch ();

  iotlb_two_stage_lookup_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  iotlb_lookup_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  always @(negedge clk_i) rsp_ch.ready <= steady || ($urandom_range(99) >= 9);

  function automatic req_t noise_req();
    req_t r;
    r.command      = 1'($urandom_range(1));
    r.virt_addr    = {$urandom, $urandom};
    r.virt_page    = VPN_W'({$urandom, $urandom});
    {r.gscid_valid, r.pscid_valid, r.guest_ctx_id, r.proc_ctx_id} =
      CTX_W'({$urandom, $urandom});
    r.priv_mode    = 1'($urandom_range(1));
    r.access_flags = 3'($urandom_range(7));
    r.sum_enable   = 1'($urandom_range(1));
    r.entry_attrs  = ATTR_W'($urandom);
    r.phys_page    = PPN_W'({$urandom, $urandom});
    return r;
  endfunction

  function automatic req_t fill_req(input logic [CTX_W-1:0] ctx, input logic [VPN_W-1:0] page,
                                    input logic [ATTR_W-1:0] attrs,
                                    input logic [PPN_W-1:0] ppn);
    req_t r;
    r = noise_req();
    r.command = CMD_FILL;
    {r.gscid_valid, r.pscid_valid, r.guest_ctx_id, r.proc_ctx_id} = ctx;
    r.virt_page   = page;
    r.entry_attrs = attrs;
    r.phys_page   = ppn;
    recent_fill.push_back(fill_tag_t'{ctx, page, attrs[AT_NAPOT]});
    if (recent_fill.size() > RECENT_MAX) void'(recent_fill.pop_front());
    return r;
  endfunction

  function automatic req_t lookup_req(input logic [CTX_W-1:0] ctx, input logic [VA_W-1:0] addr,
                                      input logic priv, input logic [2:0] acc,
                                      input logic sum);
    req_t r;
    r = noise_req();
    r.command = CMD_LOOKUP;
    {r.gscid_valid, r.pscid_valid, r.guest_ctx_id, r.proc_ctx_id} = ctx;
    r.virt_addr    = addr;
    r.priv_mode    = priv;
    r.access_flags = acc;
    r.sum_enable   = sum;
    return r;
  endfunction

  // trailing ones select the napot size, the bit above stays random
  function automatic logic [63:0] napot_encode(input logic [63:0] base, input int ones);
    logic [63:0] low;
    low = (64'd1 << ones) - 64'd1;
    return (base & ~low) | low;
  endfunction

  function automatic int pick_ones(input int top);
    return ($urandom_range(9) == 0) ? $urandom_range(top) : $urandom_range(6);
  endfunction

  function automatic req_t random_req();
    logic [CTX_W-1:0]  ctx;
    logic [VPN_W-1:0]  page;
    logic [VPN_W-1:0]  mask;
    logic [ATTR_W-1:0] attrs;
    logic [PPN_W-1:0]  ppn;
    fill_tag_t         tag;
    ctx = ($urandom_range(99) < 85) ? ctx_pool[$urandom_range(3)] : CTX_W'({$urandom, $urandom});
    if ($urandom_range(99) < 30) begin
      attrs = ATTR_W'($urandom);
      if ($urandom_range(99) < 70) attrs |= PERM_ALL;
      page = VPN_W'({$urandom, $urandom});
      ppn  = PPN_W'({$urandom, $urandom});
      if (attrs[AT_NAPOT]) begin
        page = VPN_W'(napot_encode(64'(page), pick_ones(VPN_W)));
        ppn  = PPN_W'(napot_encode(64'(ppn), pick_ones(PPN_W)));
      end
      return fill_req(ctx, page, attrs, ppn);
    end
    if (recent_fill.size() != 0 && $urandom_range(99) < 75) begin
      tag  = recent_fill[$urandom_range(recent_fill.size() - 1)];
      mask = tag.napot ? (tag.page ^ (tag.page + 1'b1)) : '0;
      page = (tag.page & ~mask) | (VPN_W'({$urandom, $urandom}) & mask);
      ctx  = tag.ctx;
      if ($urandom_range(9) == 0) ctx ^= CTX_W'(1) << $urandom_range(CTX_W - 1);
      return lookup_req(ctx, {page, PG_OFF_W'($urandom)}, 1'($urandom_range(1)),
                        3'($urandom_range(7)), 1'($urandom_range(1)));
    end
    return lookup_req(ctx, {$urandom, $urandom}, 1'($urandom_range(1)),
                      3'($urandom_range(7)), 1'($urandom_range(1)));
  endfunction

  task automatic issue_request(input req_t r);
    while (!steady && $urandom_range(99) < 9) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("iotlb_two_stage_lookup_core_tb: FAIL");
    $finish;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    ctx_pool[0]  = '0;
    ctx_pool[1]  = '1;
    ctx_pool[2]  = CTX_MID;
    ctx_pool[3]  = CTX_W'({$urandom, $urandom});
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    issue_request(lookup_req('0, '0, 1'b1, 3'b001, 1'b0));
    issue_request(fill_req('1, '1, '1, '1));
    issue_request(lookup_req('1, '1, 1'b1, 3'b001, 1'b1));
    issue_request(lookup_req('1, '0, 1'b0, 3'b011, 1'b0));
    issue_request(lookup_req('1, 64'h123, 1'b1, 3'b100, 1'b1));
    issue_request(lookup_req('1, '1, 1'b1, 3'b001, 1'b0));
    issue_request(lookup_req('1, {$urandom, $urandom}, 1'b0, 3'b000, 1'b0));
    issue_request(fill_req('0, '0, ATTR_SUPER, '0));
    issue_request(lookup_req('0, 64'hFFF, 1'b1, 3'b111, 1'b0));
    issue_request(lookup_req('0, '0, 1'b0, 3'b001, 1'b0));
    issue_request(lookup_req('0, 64'h1000, 1'b1, 3'b001, 1'b0));
    issue_request(lookup_req(CTX_W'(1) << (CTX_W - 1), '0, 1'b1, 3'b001, 1'b0));
    issue_request(fill_req('0, VPN_W'(5), ATTR_CLEAN, PPN_W'(5)));
    issue_request(lookup_req('0, 64'h5000, 1'b1, 3'b010, 1'b0));
    issue_request(lookup_req('0, 64'h5000, 1'b1, 3'b001, 1'b0));
    issue_request(fill_req(CTX_MID, VPN_W'(3), ATTR_G_RONLY, PPN_W'(44'hABC0F)));
    issue_request(lookup_req(CTX_MID, 64'h6ABC, 1'b1, 3'b001, 1'b0));
    issue_request(lookup_req(CTX_MID, 64'h6ABC, 1'b1, 3'b010, 1'b0));
    issue_request(fill_req(CTX_MID, VPN_W'(64), ATTR_NO_VS, PPN_W'(1)));
    issue_request(lookup_req(CTX_MID, 64'h40000, 1'b1, 3'b001, 1'b0));
    issue_request(lookup_req(CTX_MID, 64'h40000, 1'b1, 3'b010, 1'b0));
    issue_request(lookup_req(CTX_MID, 64'h40000, 1'b1, 3'b100, 1'b0));

    for (int i = 0; i < NUM_RANDOM; i++) begin
      steady = (i >= 500 && i < 800);
      issue_request(random_req());
    end
    steady = 1'b0;
    req_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("iotlb_two_stage_lookup_core_tb: PASS");
    end else begin
      $display("iotlb_two_stage_lookup_core_tb: FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire

>>> sim.f
sv/iotlb_pkg.sv
sv/iotlb_req_if.sv
sv/iotlb_rsp_if.sv
sv/iotlb_ctrl.sv
sv/iotlb_dpath.sv
sv/iotlb_two_stage_lookup_core.sv
sv/iotlb_checker.sv
test/iotlb_lookup_checker.sv
test/iotlb_two_stage_lookup_core_tb.sv
